FILE: hdl/ufr_pkg.sv
package ufr_pkg;

    localparam int unsigned CpW      = 21;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam int unsigned QCntW    = $clog2(QDepth + 1);
    localparam int unsigned MaxOut   = 2;
    localparam int unsigned OutCntW  = $clog2(MaxOut + 1);

    localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
    localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
    localparam logic [CpW-1:0] CyrUpLo    = 21'h000410;
    localparam logic [CpW-1:0] CyrUpHi    = 21'h00042F;
    localparam logic [CpW-1:0] CyrYoUp    = 21'h000401;
    localparam logic [CpW-1:0] CyrYoLo    = 21'h000451;
    localparam logic [CpW-1:0] CyrLoLo    = 21'h000430;
    localparam logic [CpW-1:0] CyrLoHi    = 21'h00044F;
    localparam logic [CpW-1:0] AscUpLo    = 21'h000041;
    localparam logic [CpW-1:0] AscUpHi    = 21'h00005A;
    localparam logic [CpW-1:0] AscLoLo    = 21'h000061;
    localparam logic [CpW-1:0] AscLoHi    = 21'h00007A;
    localparam logic [CpW-1:0] DigLo      = 21'h000030;
    localparam logic [CpW-1:0] DigHi      = 21'h000039;
    localparam logic [CpW-1:0] CaseOffset = 21'h000020;
    localparam logic [CpW-1:0] Min2       = 21'h000080;
    localparam logic [CpW-1:0] Min3       = 21'h000800;
    localparam logic [CpW-1:0] Min4       = 21'h010000;
    localparam logic [CpW-1:0] AsciiMax   = 21'h00007F;

    localparam logic [2:0] SeqLen2 = 3'd2;
    localparam logic [2:0] SeqLen3 = 3'd3;
    localparam logic [2:0] SeqLen4 = 3'd4;

    localparam logic [2:0] LeadTag2 = 3'b110;
    localparam logic [3:0] LeadTag3 = 4'b1110;
    localparam logic [4:0] LeadTag4 = 5'b11110;
    localparam logic [1:0] ContTag  = 2'b10;

    typedef struct packed {
        logic [CpW-1:0] acc;
        logic [1:0]     rem;
        logic [2:0]     len;
    } t_seq;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       end_of_text;
    } t_result;

endpackage

FILE: hdl/ufr_decode.sv
module ufr_decode (
    input  ufr_pkg::t_seq                   i_seq,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    output ufr_pkg::t_seq                   o_seq_next,
    output logic [ufr_pkg::OutCntW-1:0]     o_count,
    output ufr_pkg::t_result                o_res0,
    output ufr_pkg::t_result                o_res1
);
    import ufr_pkg::*;

    function automatic logic [CpW-1:0] fold_case(input logic [CpW-1:0] cp);
        logic [CpW-1:0] v;
        v = cp;
        if (cp >= AscUpLo && cp <= AscUpHi) begin
            v = cp + CaseOffset;
        end else if (cp >= CyrUpLo && cp <= CyrUpHi) begin
            v = cp + CaseOffset;
        end else if (cp == CyrYoUp) begin
            v = CyrYoLo;
        end
        return v;
    endfunction

    function automatic logic is_kept(input logic [CpW-1:0] cp);
        return (cp >= DigLo && cp <= DigHi) || (cp >= AscLoLo && cp <= AscLoHi) ||
               (cp >= CyrLoLo && cp <= CyrLoHi) || (cp == CyrYoLo);
    endfunction

    logic           is_cont;
    logic [CpW-1:0] acc_n;
    logic [1:0]     rem_n;
    logic [CpW-1:0] minimum;
    logic [CpW-1:0] cp;
    logic           cp_ok;
    logic [CpW-1:0] folded;
    logic           keep;

    assign is_cont = (i_byte[7:6] == ContTag);
    assign acc_n   = {i_seq.acc[CpW-7:0], i_byte[5:0]};
    assign rem_n   = i_seq.rem - 2'd1;

    always_comb begin
        case (i_seq.len)
            SeqLen2: minimum = Min2;
            SeqLen3: minimum = Min3;
            default: minimum = Min4;
        endcase
    end

    always_comb begin
        o_seq_next = '0;
        cp         = '0;
        cp_ok      = 1'b0;
        if (i_seq.rem != 2'd0 && is_cont) begin
            if (rem_n != 2'd0) begin
                o_seq_next = '{acc: acc_n, rem: rem_n, len: i_seq.len};
            end else begin
                cp    = acc_n;
                cp_ok = !(acc_n < minimum || acc_n > CpMax ||
                          (acc_n >= SurrLo && acc_n <= SurrHi));
            end
        end else begin
            // an open sequence broken into is dropped, the byte starts afresh
            if (!i_byte[7]) begin
                cp    = {{(CpW-8){1'b0}}, i_byte};
                cp_ok = 1'b1;
            end else if (i_byte[7:5] == LeadTag2) begin
                o_seq_next = '{acc: {{(CpW-5){1'b0}}, i_byte[4:0]}, rem: 2'd1, len: SeqLen2};
            end else if (i_byte[7:4] == LeadTag3) begin
                o_seq_next = '{acc: {{(CpW-4){1'b0}}, i_byte[3:0]}, rem: 2'd2, len: SeqLen3};
            end else if (i_byte[7:3] == LeadTag4) begin
                o_seq_next = '{acc: {{(CpW-3){1'b0}}, i_byte[2:0]}, rem: 2'd3, len: SeqLen4};
            end
        end
        if (i_last) begin
            o_seq_next = '0;
        end
    end

    assign folded = fold_case(cp);
    assign keep   = cp_ok && is_kept(folded);

    always_comb begin
        o_count = '0;
        o_res0  = '0;
        o_res1  = '{out_byte: {ContTag, folded[5:0]}, out_valid: 1'b1, end_of_text: i_last};
        if (keep) begin
            if (folded <= AsciiMax) begin
                o_count = OutCntW'(1);
                o_res0  = '{out_byte: folded[7:0], out_valid: 1'b1, end_of_text: i_last};
            end else begin
                o_count = OutCntW'(2);
                o_res0  = '{out_byte: {LeadTag2, folded[10:6]}, out_valid: 1'b1,
                            end_of_text: 1'b0};
            end
        end else if (i_last) begin
            // bare end marker
            o_count = OutCntW'(1);
            o_res0  = '{out_byte: 8'd0, out_valid: 1'b0, end_of_text: 1'b1};
        end
    end

endmodule

FILE: hdl/ufr_outq.sv
module ufr_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ufr_pkg::OutCntW-1:0]     i_push,
    input  ufr_pkg::t_result                i_res0,
    input  ufr_pkg::t_result                i_res1,
    output logic                            o_room,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ufr_pkg::t_result                o_head
);
    import ufr_pkg::*;

    t_result            r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0]   r_count, n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // room for a full two-beat character
    assign o_room  = (r_count <= QCntW'(QDepth - MaxOut));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPtrW'(i_push);
        n_rd_ptr = pop ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + QCntW'(i_push) - QCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push != '0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push == OutCntW'(2)) begin
            r_mem[r_wr_ptr + QPtrW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hdl/utf8_fold_filter_reencoder.sv
// result beats are decoded combinationally and registered in the result queue when their input byte is accepted
// throughput: one byte per cycle; a kept Cyrillic letter gives two output beats,
// drained through a four-entry result queue that holds ready low while fewer than
// two entries are free
// reset (synchronous, active low) clears the open sequence and empties the queue
// after a byte flagged last the decoder state returns to its reset values
module utf8_fold_filter_reencoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_end_of_text
);
    import ufr_pkg::*;

    t_seq                r_seq, n_seq;
    t_seq                dec_seq;
    logic [OutCntW-1:0]  dec_count;
    logic [OutCntW-1:0]  push;
    t_result             res0, res1;
    t_result             head;
    logic                room;
    logic                accept;

    assign o_ready = room;
    assign accept  = i_valid && room;

    ufr_decode u_decode (
        .i_seq      (r_seq),
        .i_byte     (i_in_byte),
        .i_last     (i_last_byte),
        .o_seq_next (dec_seq),
        .o_count    (dec_count),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    assign push  = accept ? dec_count : '0;
    assign n_seq = accept ? dec_seq : r_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else begin
            r_seq <= n_seq;
        end
    end

    ufr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_out_byte    = head.out_byte;
    assign o_out_valid   = head.out_valid;
    assign o_end_of_text = head.end_of_text;

endmodule

FILE: hdl/ufr_checker.sv
module ufr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_out_byte,
    input  logic        o_out_valid,
    input  logic        o_end_of_text
);

    // reset empties the result queue and opens the input side
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("queue not empty after reset");

    // a bare end marker only ever closes a text
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_end_of_text)
        else $error("bare marker without end of text");

    // a two-byte lead beat is never the last beat of a text
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid && o_out_byte[7] && o_out_byte[6] |-> !o_end_of_text)
        else $error("lead byte flagged as end of text");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_out_valid)
            && $stable(o_end_of_text))
        else $error("stalled output beat changed");

endmodule

bind utf8_fold_filter_reencoder ufr_checker u_ufr_checker (.*);

FILE: verif/utf8_fold_filter_reencoder_checker.sv
`timescale 1ns / 1ps

module utf8_fold_filter_reencoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_data_valid,
    input  logic       i_out_end,
    output int         o_fail_count,
    output int         o_pending
);
    import ufr_pkg::*;

    // decoder state mirrored from the byte stream
    logic [CpW-1:0] gather_cp;
    logic [1:0]     conts_left;
    logic [2:0]     open_len;

    t_result folded_q [$];
    t_result want;
    int      mismatch_cnt = 0;

    // fold case, keep only digits and letters, re-encode; returns the byte count
    function automatic int unsigned fold_encode(input logic [CpW-1:0] cp,
                                                output logic [7:0] b0,
                                                output logic [7:0] b1);
        logic [CpW-1:0] v;
        logic           keep;
        v = cp;
        if ((cp >= AscUpLo && cp <= AscUpHi) || (cp >= CyrUpLo && cp <= CyrUpHi))
            v = cp + CaseOffset;
        else if (cp == CyrYoUp)
            v = CyrYoLo;
        keep = (v >= DigLo && v <= DigHi) || (v >= AscLoLo && v <= AscLoHi) ||
               (v >= CyrLoLo && v <= CyrLoHi) || (v == CyrYoLo);
        b0 = 8'h00;
        b1 = 8'h00;
        if (!keep)
            return 0;
        if (v <= AsciiMax) begin
            b0 = v[7:0];
            return 1;
        end
        b0 = {LeadTag2, v[10:6]};
        b1 = {ContTag, v[5:0]};
        return 2;
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic v, input logic e);
        folded_q.insert(folded_q.size(), t_result'{out_byte: b, out_valid: v,
                                                   end_of_text: e});
    endtask

    task automatic fold_filter_byte(input logic [7:0] b, input logic last);
        logic [7:0]     e0;
        logic [7:0]     e1;
        int unsigned    n;
        logic [CpW-1:0] cp;
        logic [CpW-1:0] floor_cp;
        logic           as_lead;
        n       = 0;
        e0      = 8'h00;
        e1      = 8'h00;
        as_lead = 1'b1;
        if (conts_left != 2'd0) begin
            if (b[7:6] == ContTag) begin
                as_lead    = 1'b0;
                gather_cp  = {gather_cp[CpW-7:0], b[5:0]};
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0) begin
                    cp       = gather_cp;
                    floor_cp = (open_len == SeqLen2) ? Min2 :
                               (open_len == SeqLen3) ? Min3 : Min4;
                    gather_cp = '0;
                    open_len  = '0;
                    if (!(cp < floor_cp || cp > CpMax || (cp >= SurrLo && cp <= SurrHi)))
                        n = fold_encode(cp, e0, e1);
                end
            end else begin
                // break-in: drop the open sequence, then treat as a lead
                gather_cp  = '0;
                conts_left = '0;
                open_len   = '0;
            end
        end
        if (as_lead) begin
            if (!b[7]) begin
                n = fold_encode({{(CpW-8){1'b0}}, b}, e0, e1);
            end else if (b[7:5] == LeadTag2) begin
                gather_cp  = {{(CpW-5){1'b0}}, b[4:0]};
                open_len   = SeqLen2;
                conts_left = 2'd1;
            end else if (b[7:4] == LeadTag3) begin
                gather_cp  = {{(CpW-4){1'b0}}, b[3:0]};
                open_len   = SeqLen3;
                conts_left = 2'd2;
            end else if (b[7:3] == LeadTag4) begin
                gather_cp  = {{(CpW-3){1'b0}}, b[2:0]};
                open_len   = SeqLen4;
                conts_left = 2'd3;
            end
        end
        if (n >= 1)
            add_beat(e0, 1'b1, last && (n == 1));
        if (n == 2)
            add_beat(e1, 1'b1, last);
        if (last) begin
            gather_cp  = '0;
            conts_left = '0;
            open_len   = '0;
            if (n == 0)
                add_beat(8'h00, 1'b0, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gather_cp  = '0;
            conts_left = '0;
            open_len   = '0;
            folded_q.delete();
        end else begin
            // an output beat is never caused by an input taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (folded_q.size() == 0) begin
                    $display("%0t: unexpected beat: byte %02h valid %0b end %0b", $time,
                             i_out_byte, i_out_data_valid, i_out_end);
                    mismatch_cnt++;
                end else begin
                    want = folded_q.pop_front();
                    if (i_out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 want.out_byte, i_out_byte);
                        mismatch_cnt++;
                    end
                    if (i_out_data_valid !== want.out_valid) begin
                        $display("%0t: out_valid expected %0b actual %0b", $time,
                                 want.out_valid, i_out_data_valid);
                        mismatch_cnt++;
                    end
                    if (i_out_end !== want.end_of_text) begin
                        $display("%0t: end_of_text expected %0b actual %0b", $time,
                                 want.end_of_text, i_out_end);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                fold_filter_byte(i_in_byte, i_in_last);
        end
        o_pending    <= folded_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

FILE: verif/utf8_fold_filter_reencoder_tb.sv
`timescale 1ns / 1ps

module utf8_fold_filter_reencoder_tb;

    localparam int TextBytes  = 1050;
    localparam int CycleLimit = 400000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_end_of_text;

    int fail_count;
    int pending_beats;
    int cycle_cnt      = 0;
    int sent_cnt       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic [7:0] text_q [$];

    // {last, byte}: folding, extremes, stray and bad leads, then rejected sequences
    logic [8:0] directed_seq [23] = '{
        9'h041, 9'h07A, 9'h030, 9'h000, 9'h0FF, 9'h080, 9'h0D0, 9'h081, 9'h0D1, 9'h18F,
        9'h0C0, 9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080,
        9'h0D0, 9'h041, 9'h0E0, 9'h1A0
    };

    utf8_fold_filter_reencoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_valid   (o_out_valid),
        .o_end_of_text (o_end_of_text)
    );

    utf8_fold_filter_reencoder_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_last_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_out_byte       (o_out_byte),
        .i_out_data_valid (o_out_valid),
        .i_out_end        (o_end_of_text),
        .o_fail_count     (fail_count),
        .o_pending        (pending_beats)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("utf8_fold_filter_reencoder_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        sent_cnt++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // raw bit layout only: no range check, so overlong and out-of-range forms pass
    task automatic push_encoded(input logic [20:0] cp, input int n);
        case (n)
            1: add_byte(cp[7:0]);
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_char();
        int          pick;
        int          n;
        int          k;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 20) begin
            push_encoded(21'($urandom_range(8'h7F)), 1);
        end else if (pick < 45) begin
            k = $urandom_range(2);
            cp = 21'((k == 0) ? $urandom_range(8'h30, 8'h39) :
                     (k == 1) ? $urandom_range(8'h41, 8'h5A) : $urandom_range(8'h61, 8'h7A));
            push_encoded(cp, 1);
        end else if (pick < 70) begin
            push_encoded(21'($urandom_range(16'h0400, 16'h045F)), 2);
        end else if (pick < 76) begin
            push_encoded(21'($urandom_range(16'h0080, 16'h07FF)), 2);
        end else if (pick < 82) begin
            // includes the surrogate range
            push_encoded(21'($urandom_range(16'h0800, 16'hFFFF)), 3);
        end else if (pick < 87) begin
            push_encoded(21'($urandom_range(21'h010000, 21'h1FFFFF)), 4);
        end else if (pick < 91) begin
            n = $urandom_range(2, 4);
            cp = 21'((n == 2) ? $urandom_range(8'h7F) :
                     (n == 3) ? $urandom_range(16'h07FF) : $urandom_range(16'hFFFF));
            push_encoded(cp, n);
        end else if (pick < 96) begin
            add_byte(8'($urandom_range(8'hFF)));
        end else begin
            // sequence cut short, the next byte breaks in or the text ends
            n = $urandom_range(2, 4);
            push_encoded(21'($urandom_range(16'h0400, 16'hFFFF)), n);
            repeat ($urandom_range(1, n - 1)) void'(text_q.pop_back());
        end
    endtask

    initial begin
        int i;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < 23; i++)
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        while (sent_cnt < TextBytes) begin
            case ((sent_cnt / 70) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat ($urandom_range(1, 10)) add_char();
            for (i = 0; i < text_q.size(); i++)
                send_byte(text_q[i], i == text_q.size() - 1);
            text_q.delete();
        end
        i_valid <= 1'b0;

        // let the checker take in the final beat before looking at its count
        repeat (2) @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("utf8_fold_filter_reencoder_tb passed");
        end else begin
            $display("utf8_fold_filter_reencoder_tb failed");
        end
        $finish;
    end

endmodule
